>>> hw/rtl/assert_macros.svh
// Assertion shorthands for the two-wire master. Both sample on clk and
// are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/stwm_pkg.sv
package stwm_pkg;

  localparam int WaitWidth = 21;
  localparam logic [WaitWidth-1:0] WaitLimitReset = 21'd1200000;
  localparam logic [3:0] ResetClocks = 4'd9;

  // Start-condition pin pattern, bit i for tick i.
  localparam logic [6:0] TsClock = 7'b0110110;
  localparam logic [6:0] TsData  = 7'b1100011;

  typedef enum logic [2:0] {
    OpTemp     = 3'd0,
    OpHumid    = 3'd1,
    OpReadStat = 3'd2,
    OpWriteStat = 3'd3,
    OpSoftRst  = 3'd4,
    OpConnRst  = 3'd5
  } stwm_op_t;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNack    = 2'd1,
    StTimeout = 2'd2
  } stwm_status_t;

  typedef enum logic [3:0] {
    PhIdle  = 4'd0,
    PhCrHi  = 4'd1,
    PhCrLo  = 4'd2,
    PhTs    = 4'd3,
    PhWbLo  = 4'd4,
    PhWbHi  = 4'd5,
    PhAckLo = 4'd6,
    PhAckHi = 4'd7,
    PhWait  = 4'd8,
    PhRbLo  = 4'd9,
    PhRbHi  = 4'd10,
    PhMaLo  = 4'd11,
    PhMaHi  = 4'd12,
    PhDone  = 4'd13
  } stwm_phase_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] operation;
    logic [7:0] status_to_write;
    logic       data_sample;
  } stwm_in_t;

  typedef struct packed {
    logic        clock_level;
    logic        data_enable;
    logic        data_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic [7:0]  check_byte;
    logic [1:0]  status;
  } stwm_out_t;

  typedef struct packed {
    stwm_phase_t          phase;
    logic [3:0]           bit_count;
    logic [1:0]           byte_count;
    logic [15:0]          shift_word;
    logic [7:0]           check_store;
    logic [WaitWidth-1:0] wait_count;
    logic [1:0]           error_code;
    logic [2:0]           held_operation;
    logic [7:0]           held_write_byte;
  } stwm_state_t;

  localparam stwm_state_t StateReset = '{
    phase: PhIdle, bit_count: '0, byte_count: '0, shift_word: '0,
    check_store: '0, wait_count: '0, error_code: '0, held_operation: '0,
    held_write_byte: '0
  };

  // Command byte for the current write slot.
  function automatic logic [7:0] byte_to_send(input logic [2:0] op,
                                              input logic [1:0] bytes,
                                              input logic [7:0] wbyte);
    logic [7:0] b;
    case (op)
      OpTemp:      b = 8'h03;
      OpHumid:     b = 8'h05;
      OpReadStat:  b = 8'h07;
      OpWriteStat: b = (bytes != 2'd0) ? wbyte : 8'h06;
      default:     b = 8'h1E;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/stwm_step.sv
module stwm_step import stwm_pkg::*; (
  input  stwm_state_t          cur,
  input  stwm_in_t             din,
  input  logic [WaitWidth-1:0] wait_limit,
  output stwm_state_t          nxt,
  output stwm_out_t            res
);

  stwm_state_t s;
  logic        clk_o, en_o, lvl_o, busy_o, done_o;
  logic        last_rd;
  logic [3:0]  bc_inc;
  logic [3:0]  ts_idx;
  logic [7:0]  wb;

  // A request is taken only while idle and only for defined operations.
  always_comb begin
    s = cur;
    if (cur.phase == PhIdle && din.start_req && din.operation <= 3'(OpConnRst)) begin
      s = StateReset;
      s.held_operation  = din.operation;
      s.held_write_byte = din.status_to_write;
      s.phase = (din.operation >= 3'(OpSoftRst)) ? PhCrHi : PhTs;
    end
  end

  assign last_rd = (s.held_operation == 3'(OpReadStat)) ? (s.byte_count >= 2'd1)
                                                        : (s.byte_count >= 2'd2);
  assign bc_inc  = s.bit_count + 4'd1;
  assign ts_idx  = (s.bit_count > 4'd6) ? 4'd6 : s.bit_count;
  assign wb      = byte_to_send(s.held_operation, s.byte_count, s.held_write_byte);

  always_comb begin
    nxt    = s;
    clk_o  = 1'b0;
    en_o   = 1'b0;
    lvl_o  = 1'b0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (s.phase)
      PhCrHi: begin
        clk_o = 1'b1; en_o = 1'b1; lvl_o = 1'b1;
        nxt.phase = PhCrLo;
      end
      PhCrLo: begin
        en_o = 1'b1; lvl_o = 1'b1;
        if (bc_inc >= ResetClocks) begin
          nxt.bit_count = '0;
          nxt.phase = PhTs;
        end else begin
          nxt.bit_count = bc_inc;
          nxt.phase = PhCrHi;
        end
      end
      PhTs: begin
        clk_o = TsClock[ts_idx[2:0]];
        en_o  = 1'b1;
        lvl_o = TsData[ts_idx[2:0]];
        if (ts_idx + 4'd1 >= 4'd7) begin
          nxt.bit_count  = '0;
          nxt.byte_count = '0;
          nxt.phase = (s.held_operation == 3'(OpConnRst)) ? PhDone : PhWbLo;
        end else begin
          nxt.bit_count = ts_idx + 4'd1;
        end
      end
      PhWbLo: begin
        en_o  = 1'b1;
        lvl_o = wb[3'd7 - s.bit_count[2:0]];
        nxt.phase = PhWbHi;
      end
      PhWbHi: begin
        en_o  = 1'b1;
        clk_o = 1'b1;
        lvl_o = wb[3'd7 - s.bit_count[2:0]];
        if (bc_inc >= 4'd8) begin
          nxt.bit_count = '0;
          nxt.phase = PhAckLo;
        end else begin
          nxt.bit_count = bc_inc;
          nxt.phase = PhWbLo;
        end
      end
      PhAckLo: begin
        nxt.phase = PhAckHi;
      end
      PhAckHi: begin
        clk_o = 1'b1;
        if (din.data_sample && s.error_code == 2'(StOk)) nxt.error_code = 2'(StNack);
        // A measurement stops at the first missing ack; others run to the end.
        if (s.held_operation <= 3'(OpHumid)) begin
          if (din.data_sample) begin
            nxt.phase = PhDone;
          end else begin
            nxt.wait_count = '0;
            nxt.phase = PhWait;
          end
        end else if (s.held_operation == 3'(OpReadStat)) begin
          nxt.byte_count = '0;
          nxt.phase = PhRbLo;
        end else if (s.held_operation == 3'(OpWriteStat) && s.byte_count == 2'd0) begin
          nxt.byte_count = 2'd1;
          nxt.phase = PhWbLo;
        end else begin
          nxt.phase = PhDone;
        end
      end
      PhWait: begin
        if (!din.data_sample) begin
          nxt.byte_count = '0;
          nxt.bit_count  = '0;
          nxt.phase = PhRbLo;
        end else begin
          nxt.wait_count = s.wait_count + 1'b1;
          if (s.wait_count + 1'b1 >= wait_limit) begin
            nxt.error_code = 2'(StTimeout);
            nxt.phase = PhDone;
          end
        end
      end
      PhRbLo: begin
        nxt.phase = PhRbHi;
      end
      PhRbHi: begin
        clk_o = 1'b1;
        if (last_rd) nxt.check_store = {s.check_store[6:0], din.data_sample};
        else         nxt.shift_word  = {s.shift_word[14:0], din.data_sample};
        if (bc_inc >= 4'd8) begin
          nxt.bit_count = '0;
          nxt.phase = PhMaLo;
        end else begin
          nxt.bit_count = bc_inc;
          nxt.phase = PhRbLo;
        end
      end
      PhMaLo: begin
        en_o  = 1'b1;
        lvl_o = last_rd;
        nxt.phase = PhMaHi;
      end
      PhMaHi: begin
        en_o  = 1'b1;
        lvl_o = last_rd;
        clk_o = 1'b1;
        if (last_rd) begin
          nxt.phase = PhDone;
        end else begin
          nxt.byte_count = s.byte_count + 2'd1;
          nxt.phase = PhRbLo;
        end
      end
      PhDone: begin
        busy_o = 1'b0;
        done_o = 1'b1;
        nxt.phase = PhIdle;
      end
      default: begin
        busy_o = 1'b0;
        nxt.phase = PhIdle;
      end
    endcase
  end

  always_comb begin
    res.clock_level = clk_o;
    res.data_enable = en_o;
    res.data_level  = en_o & lvl_o;
    res.busy_res    = busy_o;
    res.done_res    = done_o;
    res.read_value  = done_o ? s.shift_word  : 16'd0;
    res.check_byte  = done_o ? s.check_store : 8'd0;
    res.status      = done_o ? s.error_code  : 2'd0;
  end

endmodule

>>> hw/rtl/sensor_two_wire_master_core.sv
// Two-wire sensor master: one pin-timing tick per input transaction.
// The result of a tick is registered and is valid in the cycle after it is accepted.
// Throughput: one tick per cycle while out_ready is high; besides the wait limit,
// the sequencer state and one output register are the only storage, so a new
// tick is taken while the last result is being taken.
// Reset (rst, synchronous): sequencer idle, output empty, wait limit 1200000.
`include "assert_macros.svh"

module sensor_two_wire_master_core import stwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  stwm_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output stwm_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [WaitWidth-1:0] cfg_wdata
);

  stwm_state_t          st;
  stwm_state_t          st_next;
  stwm_out_t            res_next;
  logic [WaitWidth-1:0] wait_limit;
  logic                 in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  stwm_step u_step (
    .cur        (st),
    .din        (in_data),
    .wait_limit (wait_limit),
    .nxt        (st_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_limit <= WaitLimitReset;
    end else if (cfg_we) begin
      wait_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= StateReset;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res_next;
    end
  end

  `STWM_ASSERT_NOW(a_done_not_busy, out_valid && out_data.done_res, !out_data.busy_res, "done tick marked busy")
  `STWM_ASSERT_NOW(a_quiet_results, out_valid && !out_data.done_res, out_data.status == 2'd0 && out_data.read_value == 16'd0 && out_data.check_byte == 8'd0, "results reported outside done tick")
  `STWM_ASSERT_NOW(a_released_low, out_valid && !out_data.data_enable, !out_data.data_level, "data level high while released")
  `STWM_ASSERT_NEXT(a_done_to_idle, in_fire && res_next.done_res, st.phase == PhIdle, "sequencer not idle after done")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import stwm_pkg::*;

  // Operation codes that the block must ignore.
  localparam logic [2:0] OpUnusedA = 3'd6;
  localparam logic [2:0] OpUnusedB = 3'd7;

  // Start condition, bit i for tick i.
  localparam logic [6:0] StartClock = 7'b0110110;
  localparam logic [6:0] StartData  = 7'b1100011;

  localparam int ResetClockPairs = 9;
  localparam int WatchdogLimit = 2000;
  localparam int HoldAfterResults = 200;
  localparam int HoldCycles = 120;
  localparam logic [WaitWidth-1:0] WaitLimitMax = 21'd2097151;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  stwm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stwm_out_t out_data;
  logic cfg_we = 1'b0;
  logic [WaitWidth-1:0] cfg_wdata = '0;

  sensor_two_wire_master_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  stwm_in_t pending_ticks[$];
  stwm_out_t expected_pins[$];
  int owed_results = 0;
  int ticks_queued = 0;
  int results_seen = 0;
  int failures = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;

  // Sequencer copy that tracks the block tick by tick.
  logic [WaitWidth-1:0] wait_limit_model = WaitLimitReset;
  stwm_phase_t seq_phase = PhIdle;
  logic [3:0] bits_done = '0;
  logic [1:0] bytes_done = '0;
  logic [15:0] word_acc = '0;
  logic [7:0] chk_acc = '0;
  logic [WaitWidth-1:0] wait_ticks = '0;
  logic [1:0] err_code = StOk;
  logic [2:0] cur_op = '0;
  logic [7:0] cur_wbyte = '0;

  function automatic logic [7:0] command_byte();
    logic [7:0] cmd;
    case (cur_op)
      OpTemp: cmd = 8'h03;
      OpHumid: cmd = 8'h05;
      OpReadStat: cmd = 8'h07;
      OpWriteStat: cmd = (bytes_done != 2'd0) ? cur_wbyte : 8'h06;
      default: cmd = 8'h1E;
    endcase
    return cmd;
  endfunction

  // A status read returns one byte before the checksum, a measurement two.
  function automatic logic final_byte();
    return bytes_done >= ((cur_op == OpReadStat) ? 2'd1 : 2'd2);
  endfunction

  task automatic sequence_tick(input stwm_in_t t, output stwm_out_t r);
    logic lvl;
    logic [7:0] cmd;
    r = '0;
    r.busy_res = 1'b1;
    lvl = 1'b0;
    if (seq_phase == PhIdle && t.start_req && t.operation <= OpConnRst) begin
      cur_op = t.operation;
      cur_wbyte = t.status_to_write;
      bits_done = '0;
      bytes_done = '0;
      word_acc = '0;
      chk_acc = '0;
      wait_ticks = '0;
      err_code = StOk;
      seq_phase = (t.operation >= OpSoftRst) ? PhCrHi : PhTs;
    end
    case (seq_phase)
      PhCrHi: begin
        r.clock_level = 1'b1;
        r.data_enable = 1'b1;
        lvl = 1'b1;
        seq_phase = PhCrLo;
      end
      PhCrLo: begin
        r.data_enable = 1'b1;
        lvl = 1'b1;
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'(ResetClockPairs)) begin
          bits_done = '0;
          seq_phase = PhTs;
        end else begin
          seq_phase = PhCrHi;
        end
      end
      PhTs: begin
        if (bits_done > 4'd6) bits_done = 4'd6;
        r.clock_level = StartClock[bits_done[2:0]];
        r.data_enable = 1'b1;
        lvl = StartData[bits_done[2:0]];
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd7) begin
          bits_done = '0;
          bytes_done = '0;
          seq_phase = (cur_op == OpConnRst) ? PhDone : PhWbLo;
        end
      end
      PhWbLo, PhWbHi: begin
        r.data_enable = 1'b1;
        cmd = command_byte();
        lvl = cmd[3'd7 - bits_done[2:0]];
        if (seq_phase == PhWbLo) begin
          seq_phase = PhWbHi;
        end else begin
          r.clock_level = 1'b1;
          bits_done = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            bits_done = '0;
            seq_phase = PhAckLo;
          end else begin
            seq_phase = PhWbLo;
          end
        end
      end
      PhAckLo: seq_phase = PhAckHi;
      PhAckHi: begin
        r.clock_level = 1'b1;
        if (t.data_sample && err_code == StOk) err_code = StNack;
        // A measurement gives up on a missing ack; other operations run on.
        if (t.data_sample && cur_op <= OpHumid) begin
          seq_phase = PhDone;
        end else if (cur_op <= OpHumid) begin
          wait_ticks = '0;
          seq_phase = PhWait;
        end else if (cur_op == OpReadStat) begin
          bytes_done = '0;
          seq_phase = PhRbLo;
        end else if (cur_op == OpWriteStat && bytes_done == 2'd0) begin
          bytes_done = 2'd1;
          seq_phase = PhWbLo;
        end else begin
          seq_phase = PhDone;
        end
      end
      PhWait: begin
        if (!t.data_sample) begin
          bytes_done = '0;
          bits_done = '0;
          seq_phase = PhRbLo;
        end else begin
          wait_ticks = wait_ticks + 1'b1;
          if (wait_ticks >= wait_limit_model) begin
            err_code = StTimeout;
            seq_phase = PhDone;
          end
        end
      end
      PhRbLo: seq_phase = PhRbHi;
      PhRbHi: begin
        r.clock_level = 1'b1;
        if (final_byte()) chk_acc = {chk_acc[6:0], t.data_sample};
        else word_acc = {word_acc[14:0], t.data_sample};
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          bits_done = '0;
          seq_phase = PhMaLo;
        end else begin
          seq_phase = PhRbLo;
        end
      end
      PhMaLo, PhMaHi: begin
        r.data_enable = 1'b1;
        lvl = final_byte();
        if (seq_phase == PhMaLo) begin
          seq_phase = PhMaHi;
        end else begin
          r.clock_level = 1'b1;
          if (final_byte()) begin
            seq_phase = PhDone;
          end else begin
            bytes_done = bytes_done + 2'd1;
            seq_phase = PhRbLo;
          end
        end
      end
      PhDone: begin
        r.busy_res = 1'b0;
        r.done_res = 1'b1;
        r.read_value = word_acc;
        r.check_byte = chk_acc;
        r.status = err_code;
        seq_phase = PhIdle;
      end
      default: begin
        r.busy_res = 1'b0;
        seq_phase = PhIdle;
      end
    endcase
    r.data_level = r.data_enable & lvl;
  endtask

  task automatic push_tick(input logic req, input logic [2:0] op, input logic [7:0] wbyte,
                           input logic ds);
    stwm_in_t t;
    t.start_req = req;
    t.operation = op;
    t.status_to_write = wbyte;
    t.data_sample = ds;
    pending_ticks.push_back(t);
    owed_results++;
    ticks_queued++;
  endtask

  // Tick inside a transaction; any request on it must be ignored.
  task automatic push_busy_tick(input logic ds);
    push_tick($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)), 8'($urandom), ds);
  endtask

  // Tick between transactions; a request here names an unused operation.
  task automatic push_gap_tick();
    logic req;
    logic [2:0] op;
    req = 1'($urandom_range(0, 1));
    op = 3'($urandom_range(0, 7));
    if (req) op = ($urandom_range(0, 1) != 0) ? OpUnusedA : OpUnusedB;
    push_tick(req, op, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // Queues one whole transaction, placing the sensor's answers on the ticks
  // where the block samples them. wait_high at or above the limit times out.
  task automatic queue_transaction(input logic [2:0] op, input logic [7:0] wbyte,
                                   input logic nack_cmd, input logic nack_data,
                                   input int wait_high);
    int lead;
    lead = (op >= OpSoftRst) ? 2 * ResetClockPairs : 0;
    push_tick(1'b1, op, wbyte, 1'($urandom_range(0, 1)));
    if (op == OpConnRst) begin
      repeat (25) push_busy_tick(1'($urandom_range(0, 1)));
    end else begin
      repeat (lead + 23) push_busy_tick(1'($urandom_range(0, 1)));
      push_busy_tick(nack_cmd);
      case (op)
        OpTemp, OpHumid: begin
          if (!nack_cmd) begin
            if (wait_high >= int'(wait_limit_model)) begin
              repeat (wait_limit_model) push_busy_tick(1'b1);
            end else begin
              repeat (wait_high) push_busy_tick(1'b1);
              push_busy_tick(1'b0);
              repeat (54) push_busy_tick(1'($urandom_range(0, 1)));
            end
          end
          push_busy_tick(1'($urandom_range(0, 1)));
        end
        OpReadStat: repeat (37) push_busy_tick(1'($urandom_range(0, 1)));
        OpWriteStat: begin
          repeat (17) push_busy_tick(1'($urandom_range(0, 1)));
          push_busy_tick(nack_data);
          push_busy_tick(1'($urandom_range(0, 1)));
        end
        default: push_busy_tick(1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic queue_random_ticks(input int count);
    int stop_at;
    int wait_high;
    int wait_span;
    stop_at = ticks_queued + count;
    while (ticks_queued < stop_at) begin
      wait_span = (int'(wait_limit_model) > 13) ? 12 : int'(wait_limit_model) - 1;
      wait_high = $urandom_range(0, wait_span);
      if (int'(wait_limit_model) <= 64 && $urandom_range(0, 3) == 0) begin
        wait_high = int'(wait_limit_model);
      end
      queue_transaction(3'($urandom_range(0, 5)), 8'($urandom), $urandom_range(0, 7) == 0,
                        $urandom_range(0, 7) == 0, wait_high);
      repeat ($urandom_range(0, 3)) push_gap_tick();
    end
  endtask

  // Waits until every result is in and the sequencer is back at idle.
  task automatic settle_sequencer();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      while (owed_results > 0) @(posedge clk);
      repeat (3) @(posedge clk);
      if (seq_phase == PhIdle) settled = 1'b1;
      else repeat (8) push_gap_tick();
    end
  endtask

  task automatic write_wait_limit(input logic [WaitWidth-1:0] value);
    settle_sequencer();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    wait_limit_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : drive_ticks
    stwm_out_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sequence_tick(in_data, predicted);
        expected_pins.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 19)) begin
          in_data <= pending_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    stwm_out_t want;
    int hold_left;
    bit held_once;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      held_once = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        owed_results--;
        if (expected_pins.size() == 0) begin
          $error("result arrived with no transaction outstanding");
          failures++;
        end else begin
          want = expected_pins.pop_front();
          compare_field("clock_level", 16'(want.clock_level), 16'(out_data.clock_level));
          compare_field("data_enable", 16'(want.data_enable), 16'(out_data.data_enable));
          compare_field("data_level", 16'(want.data_level), 16'(out_data.data_level));
          compare_field("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
          compare_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
          compare_field("read_value", want.read_value, out_data.read_value);
          compare_field("check_byte", 16'(want.check_byte), 16'(out_data.check_byte));
          compare_field("status", 16'(want.status), 16'(out_data.status));
        end
      end
      // One long hold-off lets the output fill up and back-pressure the input.
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= HoldAfterResults && !held_once) begin
        held_once = 1'b1;
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Every operation at the reset wait limit, with both ack outcomes.
    queue_transaction(OpTemp, 8'h00, 1'b0, 1'b0, 0);
    queue_transaction(OpHumid, 8'hFF, 1'b0, 1'b0, 3);
    queue_transaction(OpReadStat, 8'h5A, 1'b0, 1'b0, 0);
    queue_transaction(OpWriteStat, 8'h00, 1'b0, 1'b0, 0);
    queue_transaction(OpWriteStat, 8'hFF, 1'b0, 1'b1, 0);
    queue_transaction(OpSoftRst, 8'hA5, 1'b1, 1'b0, 0);
    queue_transaction(OpConnRst, 8'h3C, 1'b0, 1'b0, 0);
    queue_transaction(OpTemp, 8'h81, 1'b1, 1'b0, 0);
    queue_transaction(OpReadStat, 8'h7E, 1'b1, 1'b0, 0);
    push_tick(1'b1, OpUnusedA, 8'hFF, 1'b0);
    push_tick(1'b1, OpUnusedB, 8'h00, 1'b1);

    // Smallest limit: the first high tick of the ready wait times out.
    write_wait_limit(21'd1);
    queue_transaction(OpTemp, 8'h00, 1'b0, 1'b0, 1);
    queue_transaction(OpHumid, 8'hFF, 1'b0, 1'b0, 0);
    queue_random_ticks(10);

    write_wait_limit(WaitLimitMax);
    no_gaps = 1'b1;
    queue_random_ticks(60);
    settle_sequencer();
    no_gaps = 1'b0;

    write_wait_limit(WaitWidth'($urandom_range(2, 40)));
    queue_random_ticks(10);

    while (owed_results > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
